// ===== sv/rcl_pkg.sv =====
// Shared types, constants and the rule program of the radical composition lookup.
package rcl_pkg;

  localparam int TableDepth = 4096;
  localparam int CharW      = 16;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = AddrW + 1;
  localparam int EntryW     = 3 * CharW;
  localparam int NumRules   = 36;
  localparam int RuleIdxW   = $clog2(NumRules);
  localparam int NumPrep    = 8;
  localparam int PrepIdxW   = $clog2(NumPrep);
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 16;
  localparam logic [CharW-1:0] NullReset = CharW'(20044);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALGO_MODE = 1'b0,
    REG_NULL_PART = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CA, OP_CB, OP_A, OP_B, OP_A1, OP_A2, OP_B1, OP_B2,
    OP_A11, OP_A12, OP_A21, OP_A22, OP_R
  } op_e;

  typedef enum logic [1:0] {
    RK_PAIR, RK_CHAIN, RK_TAKE
  } rk_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_PREP_WAIT, ST_RULE, ST_SCAN1, ST_CHAIN, ST_SCAN2, ST_DONE
  } state_e;

  typedef struct packed {
    rk_e  kind;
    logic ext;
    op_e  n0;
    op_e  n1;
    op_e  n2;
    op_e  eql;
    op_e  eq1;
    op_e  eq2;
    op_e  x;
    op_e  y;
    op_e  u;
    op_e  v;
  } rule_t;

  typedef struct packed {
    logic                ld_in;
    logic                do_load;
    logic                do_clear;
    logic                prep_start;
    logic                prep_cap;
    logic                prep_zero;
    logic                rule_start1;
    logic                rule_start2;
    logic                cap_r;
    logic                swap;
    logic                res_take;
    logic                res_scan;
    logic [RuleIdxW-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic scan_nz;
    logic scan_ok;
    logic rule_skip;
    rk_e  kind;
    logic take_ok;
    logic prep_skip;
  } dp_stat_t;

  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [EntryW-1:0] wdata;
    logic             start;
    logic             match_c;
    logic [CharW-1:0] key_a;
    logic [CharW-1:0] key_b;
  } st_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [CharW-1:0] ea;
    logic [CharW-1:0] eb;
    logic [CharW-1:0] ec;
    logic             full;
  } st_rsp_t;

  function automatic rule_t mk(rk_e k, logic e, op_e n0, op_e n1, op_e n2,
                               op_e eql, op_e eq1, op_e eq2,
                               op_e x, op_e y, op_e u, op_e v);
    rule_t r;
    r.kind = k; r.ext = e; r.n0 = n0; r.n1 = n1; r.n2 = n2;
    r.eql = eql; r.eq1 = eq1; r.eq2 = eq2;
    r.x = x; r.y = y; r.u = u; r.v = v;
    return r;
  endfunction

  function automatic rule_t rule_f(logic [RuleIdxW-1:0] idx);
    rule_t r;
    r = mk(RK_PAIR, 1'b1, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
           OP_NONE, OP_NONE, OP_NONE, OP_NONE);
    case (int'(idx))
      0: r = mk(RK_PAIR, 1'b0, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                OP_CA, OP_CB, OP_NONE, OP_NONE);
      1: r = mk(RK_PAIR, 1'b0, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                OP_A, OP_B, OP_NONE, OP_NONE);
      2: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_A2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                OP_A1, OP_B, OP_R, OP_A2);
      3: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_A2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                OP_A2, OP_B, OP_A1, OP_R);
      4: r = mk(RK_CHAIN, 1'b1, OP_B1, OP_B2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                OP_A, OP_B1, OP_R, OP_B2);
      5: r = mk(RK_CHAIN, 1'b1, OP_B1, OP_B2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                OP_A, OP_B2, OP_B1, OP_R);
      6: r = mk(RK_TAKE, 1'b0, OP_A1, OP_A2, OP_NONE, OP_A2, OP_B, OP_B,
                OP_A1, OP_NONE, OP_NONE, OP_NONE);
      7: r = mk(RK_TAKE, 1'b0, OP_A1, OP_A2, OP_NONE, OP_A1, OP_B, OP_B,
                OP_A2, OP_NONE, OP_NONE, OP_NONE);
      8: r = mk(RK_PAIR, 1'b1, OP_A2, OP_A11, OP_A12, OP_A12, OP_B, OP_B,
                OP_A11, OP_A2, OP_NONE, OP_NONE);
      9: r = mk(RK_PAIR, 1'b1, OP_A2, OP_A11, OP_A12, OP_A11, OP_B, OP_B,
                OP_A12, OP_A2, OP_NONE, OP_NONE);
      10: r = mk(RK_PAIR, 1'b1, OP_A1, OP_A21, OP_A22, OP_A22, OP_B, OP_B,
                 OP_A1, OP_A21, OP_NONE, OP_NONE);
      11: r = mk(RK_PAIR, 1'b1, OP_A1, OP_A21, OP_A22, OP_A21, OP_B, OP_B,
                 OP_A1, OP_A22, OP_NONE, OP_NONE);
      12: r = mk(RK_PAIR, 1'b0, OP_A, OP_B1, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A, OP_B1, OP_NONE, OP_NONE);
      13: r = mk(RK_PAIR, 1'b0, OP_A, OP_B2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A, OP_B2, OP_NONE, OP_NONE);
      14: r = mk(RK_PAIR, 1'b0, OP_A1, OP_B, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B, OP_NONE, OP_NONE);
      15: r = mk(RK_PAIR, 1'b0, OP_A2, OP_B, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B, OP_NONE, OP_NONE);
      16: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_A2, OP_B1, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B1, OP_R, OP_A2);
      17: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_A2, OP_B1, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B1, OP_A1, OP_R);
      18: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_A2, OP_B2, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B2, OP_R, OP_A2);
      19: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_A2, OP_B2, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B2, OP_A1, OP_R);
      20: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_B1, OP_B2, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B1, OP_R, OP_B2);
      21: r = mk(RK_CHAIN, 1'b1, OP_A1, OP_B1, OP_B2, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B2, OP_B1, OP_R);
      22: r = mk(RK_CHAIN, 1'b1, OP_A2, OP_B1, OP_B2, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B1, OP_R, OP_B2);
      23: r = mk(RK_CHAIN, 1'b1, OP_A2, OP_B1, OP_B2, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B2, OP_B1, OP_R);
      24: r = mk(RK_PAIR, 1'b0, OP_A1, OP_B1, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B1, OP_NONE, OP_NONE);
      25: r = mk(RK_PAIR, 1'b0, OP_A1, OP_B2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A1, OP_B2, OP_NONE, OP_NONE);
      26: r = mk(RK_PAIR, 1'b0, OP_A2, OP_B1, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B1, OP_NONE, OP_NONE);
      27: r = mk(RK_PAIR, 1'b0, OP_A2, OP_B2, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                 OP_A2, OP_B2, OP_NONE, OP_NONE);
      28: r = mk(RK_TAKE, 1'b0, OP_A2, OP_B1, OP_NONE, OP_A2, OP_B1, OP_B1,
                 OP_A1, OP_NONE, OP_NONE, OP_NONE);
      29: r = mk(RK_TAKE, 1'b0, OP_A2, OP_B2, OP_NONE, OP_A2, OP_B2, OP_B2,
                 OP_A1, OP_NONE, OP_NONE, OP_NONE);
      30: r = mk(RK_TAKE, 1'b0, OP_A1, OP_B1, OP_NONE, OP_A1, OP_B1, OP_B1,
                 OP_A2, OP_NONE, OP_NONE, OP_NONE);
      31: r = mk(RK_TAKE, 1'b0, OP_A1, OP_B2, OP_NONE, OP_A1, OP_B2, OP_B2,
                 OP_A2, OP_NONE, OP_NONE, OP_NONE);
      32: r = mk(RK_PAIR, 1'b1, OP_A2, OP_A11, OP_A12, OP_A12, OP_B1, OP_B2,
                 OP_A11, OP_A2, OP_NONE, OP_NONE);
      33: r = mk(RK_PAIR, 1'b1, OP_A2, OP_A11, OP_A12, OP_A11, OP_B1, OP_B2,
                 OP_A12, OP_A2, OP_NONE, OP_NONE);
      34: r = mk(RK_PAIR, 1'b1, OP_A1, OP_A21, OP_A22, OP_A22, OP_B1, OP_B2,
                 OP_A1, OP_A21, OP_NONE, OP_NONE);
      35: r = mk(RK_PAIR, 1'b1, OP_A1, OP_A21, OP_A22, OP_A21, OP_B1, OP_B2,
                 OP_A1, OP_A22, OP_NONE, OP_NONE);
      default: r = mk(RK_PAIR, 1'b1, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_NONE,
                      OP_NONE, OP_NONE, OP_NONE, OP_NONE);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/radical_composition_lookup.sv =====
// Top level of the radical composition lookup: configuration registers and block wiring.
//
// One item is taken at a time: busy stays high from the accepting edge until the cycle
// after the result strobe done_o, which lasts exactly one cycle and cannot be held off.
// Load, clear and unused commands go straight to the done state. A query is a sequence
// of first-match scans over the N loaded entries through the single read port of the
// entry memory, one entry per cycle, each scan started from a rule or decomposition step.
// Up to eight decomposition scans precede up to 84 rule scans (in each of the two
// operand orders, 18 rules with one scan and 12 chained rules with two).

module radical_composition_lookup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic [rcl_pkg::CharW-1:0]    first_char_i,
  input  logic [rcl_pkg::CharW-1:0]    second_char_i,
  input  logic [rcl_pkg::CharW-1:0]    third_char_i,
  output logic                         done_o,
  output logic [rcl_pkg::CharW-1:0]    result_char_o,
  output logic                         found_o,
  output logic                         status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rcl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcl_pkg::CfgDataW-1:0] cfg_data_i
);

  logic                      algo_mode_q;
  logic [rcl_pkg::CharW-1:0] null_code_q;
  rcl_pkg::ctrl_cmd_t        cmd;
  rcl_pkg::dp_stat_t         stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algo_mode_q <= 1'b0;
      null_code_q <= rcl_pkg::NullReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcl_pkg::REG_ALGO_MODE: algo_mode_q <= cfg_data_i[0];
        rcl_pkg::REG_NULL_PART: null_code_q <= rcl_pkg::CharW'(cfg_data_i);
        default: algo_mode_q <= algo_mode_q;
      endcase
    end
  end

  rcl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  rcl_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_cmd_i      (cmd_i),
    .first_char_i  (first_char_i),
    .second_char_i (second_char_i),
    .third_char_i  (third_char_i),
    .algo_mode_i   (algo_mode_q),
    .null_code_i   (null_code_q),
    .stat_o        (stat),
    .result_char_o (result_char_o),
    .status_o      (status_o)
  );

  assign found_o = result_char_o != '0;

endmodule

// ===== sv/rcl_store.sv =====
// Entry memory, entry count and the first-match scan engine.
module rcl_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcl_pkg::st_req_t req_i,
  output rcl_pkg::st_rsp_t rsp_o
);

  logic [rcl_pkg::EntryW-1:0] mem [rcl_pkg::TableDepth];
  logic [rcl_pkg::EntryW-1:0] rd_q;
  logic [rcl_pkg::EntryW-1:0] ent_q;
  logic [rcl_pkg::CntW-1:0]   count_q;
  logic [rcl_pkg::CntW-1:0]   idx_q;
  logic                       act_q, pend_q, last_q, done_q, hit_q;
  logic                       match_c_q;
  logic [rcl_pkg::CharW-1:0]  key_a_q, key_b_q;
  logic                       full, rd_en, match;
  logic [rcl_pkg::CharW-1:0]  ra, rb, rc;

  assign full  = count_q == rcl_pkg::CntW'(rcl_pkg::TableDepth);
  assign rd_en = act_q && (idx_q < count_q);
  assign ra = rd_q[3*rcl_pkg::CharW-1:2*rcl_pkg::CharW];
  assign rb = rd_q[2*rcl_pkg::CharW-1:rcl_pkg::CharW];
  assign rc = rd_q[rcl_pkg::CharW-1:0];
  assign match = match_c_q ? (rc == key_a_q) : (ra == key_a_q && rb == key_b_q);

  always_ff @(posedge clk_i) begin
    if (req_i.wr && !full) begin
      mem[count_q[rcl_pkg::AddrW-1:0]] <= req_i.wdata;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[rcl_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      match_c_q <= req_i.match_c;
      key_a_q   <= req_i.key_a;
      key_b_q   <= req_i.key_b;
    end
    if (pend_q && match) begin
      ent_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      act_q   <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (req_i.clr) begin
        count_q <= '0;
      end else if (req_i.wr && !full) begin
        count_q <= count_q + 1'b1;
      end
      if (req_i.start) begin
        idx_q  <= '0;
        act_q  <= count_q != '0;
        pend_q <= 1'b0;
        done_q <= count_q == '0;
        hit_q  <= 1'b0;
      end else begin
        done_q <= 1'b0;
        if (rd_en) begin
          pend_q <= 1'b1;
          last_q <= (idx_q + 1'b1) == count_q;
          idx_q  <= idx_q + 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q && (match || last_q)) begin
          done_q <= 1'b1;
          hit_q  <= match;
          act_q  <= 1'b0;
          pend_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit  = hit_q;
  assign rsp_o.ea   = ent_q[3*rcl_pkg::CharW-1:2*rcl_pkg::CharW];
  assign rsp_o.eb   = ent_q[2*rcl_pkg::CharW-1:rcl_pkg::CharW];
  assign rsp_o.ec   = ent_q[rcl_pkg::CharW-1:0];
  assign rsp_o.full = full;

endmodule

// ===== sv/rcl_dpath.sv =====
// Query operand registers, rule evaluation and result registers.
module rcl_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rcl_pkg::ctrl_cmd_t        cmd_i,
  input  logic [1:0]                in_cmd_i,
  input  logic [rcl_pkg::CharW-1:0] first_char_i,
  input  logic [rcl_pkg::CharW-1:0] second_char_i,
  input  logic [rcl_pkg::CharW-1:0] third_char_i,
  input  logic                      algo_mode_i,
  input  logic [rcl_pkg::CharW-1:0] null_code_i,
  output rcl_pkg::dp_stat_t         stat_o,
  output logic [rcl_pkg::CharW-1:0] result_char_o,
  output logic                      status_o
);

  logic [rcl_pkg::CharW-1:0] ca_q, cb_q, a_q, b_q, a1_q, a2_q, b1_q, b2_q, r_q;
  logic [rcl_pkg::CharW-1:0] p11_q, p12_q, p21_q, p22_q, q11_q, q12_q, q21_q, q22_q;
  logic [rcl_pkg::CharW-1:0] res_q;
  logic                      stat_q;
  rcl_pkg::st_req_t          req;
  rcl_pkg::st_rsp_t          rsp;
  rcl_pkg::rule_t            rule;
  logic [rcl_pkg::PrepIdxW-1:0] pidx;
  logic [rcl_pkg::CharW-1:0] pkey, sval, xv;
  logic                      nz_fail, eq_fail;

  function automatic logic [rcl_pkg::CharW-1:0] opv(rcl_pkg::op_e o);
    logic [rcl_pkg::CharW-1:0] v;
    v = '0;
    case (o)
      rcl_pkg::OP_CA:  v = ca_q;
      rcl_pkg::OP_CB:  v = cb_q;
      rcl_pkg::OP_A:   v = a_q;
      rcl_pkg::OP_B:   v = b_q;
      rcl_pkg::OP_A1:  v = a1_q;
      rcl_pkg::OP_A2:  v = a2_q;
      rcl_pkg::OP_B1:  v = b1_q;
      rcl_pkg::OP_B2:  v = b2_q;
      rcl_pkg::OP_A11: v = p11_q;
      rcl_pkg::OP_A12: v = p12_q;
      rcl_pkg::OP_A21: v = p21_q;
      rcl_pkg::OP_A22: v = p22_q;
      rcl_pkg::OP_R:   v = r_q;
      default:         v = '0;
    endcase
    return v;
  endfunction

  function automatic logic nzbad(rcl_pkg::op_e o);
    return (o != rcl_pkg::OP_NONE) && (opv(o) == '0);
  endfunction

  function automatic logic [rcl_pkg::CharW-1:0] denull(logic [rcl_pkg::CharW-1:0] v);
    return (v == null_code_i) ? '0 : v;
  endfunction

  assign rule = rcl_pkg::rule_f(cmd_i.idx);
  assign pidx = cmd_i.idx[rcl_pkg::PrepIdxW-1:0];
  assign sval = rsp.hit ? rsp.ec : '0;
  assign xv   = opv(rule.x);

  always_comb begin
    unique case (pidx)
      3'd0:    pkey = ca_q;
      3'd1:    pkey = cb_q;
      3'd2:    pkey = a_q;
      3'd3:    pkey = b_q;
      3'd4:    pkey = a1_q;
      3'd5:    pkey = a2_q;
      3'd6:    pkey = b1_q;
      default: pkey = b2_q;
    endcase
  end

  assign nz_fail = nzbad(rule.n0) || nzbad(rule.n1) || nzbad(rule.n2);
  assign eq_fail = (rule.eql != rcl_pkg::OP_NONE) &&
                   !(opv(rule.eql) == opv(rule.eq1) || opv(rule.eql) == opv(rule.eq2));

  assign stat_o.scan_done = rsp.done;
  assign stat_o.scan_nz   = sval != '0;
  assign stat_o.scan_ok   = (sval != '0) && (sval != ca_q) && (sval != cb_q);
  assign stat_o.rule_skip = (rule.ext && !algo_mode_i) || nz_fail || eq_fail;
  assign stat_o.kind      = rule.kind;
  assign stat_o.take_ok   = (xv != ca_q) && (xv != cb_q);
  assign stat_o.prep_skip = pidx[rcl_pkg::PrepIdxW-1] && (!algo_mode_i || pkey == '0);

  always_comb begin
    req.wr      = cmd_i.do_load;
    req.clr     = cmd_i.do_clear;
    req.wdata   = {first_char_i, second_char_i, third_char_i};
    req.start   = cmd_i.prep_start || cmd_i.rule_start1 || cmd_i.rule_start2;
    req.match_c = cmd_i.prep_start;
    req.key_a   = pkey;
    req.key_b   = '0;
    if (cmd_i.rule_start1) begin
      req.key_a = opv(rule.x);
      req.key_b = opv(rule.y);
    end else if (cmd_i.rule_start2) begin
      req.key_a = opv(rule.u);
      req.key_b = opv(rule.v);
    end
  end

  rcl_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      ca_q   <= first_char_i;
      cb_q   <= second_char_i;
      res_q  <= '0;
      stat_q <= (in_cmd_i == rcl_pkg::CMD_LOAD) && rsp.full;
    end
    if (cmd_i.prep_cap) begin
      unique case (pidx)
        3'd0: a_q <= (rsp.hit && rsp.ea == null_code_i) ? rsp.eb : ca_q;
        3'd1: b_q <= (rsp.hit && rsp.ea == null_code_i) ? rsp.eb : cb_q;
        3'd2: begin
          a1_q <= rsp.hit ? denull(rsp.ea) : '0;
          a2_q <= rsp.hit ? denull(rsp.eb) : '0;
        end
        3'd3: begin
          b1_q <= rsp.hit ? denull(rsp.ea) : '0;
          b2_q <= rsp.hit ? denull(rsp.eb) : '0;
        end
        3'd4: begin
          p11_q <= rsp.hit ? denull(rsp.ea) : '0;
          p12_q <= rsp.hit ? denull(rsp.eb) : '0;
        end
        3'd5: begin
          p21_q <= rsp.hit ? denull(rsp.ea) : '0;
          p22_q <= rsp.hit ? denull(rsp.eb) : '0;
        end
        3'd6: begin
          q11_q <= rsp.hit ? denull(rsp.ea) : '0;
          q12_q <= rsp.hit ? denull(rsp.eb) : '0;
        end
        default: begin
          q21_q <= rsp.hit ? denull(rsp.ea) : '0;
          q22_q <= rsp.hit ? denull(rsp.eb) : '0;
        end
      endcase
    end
    if (cmd_i.prep_zero) begin
      unique case (pidx)
        3'd4: begin
          p11_q <= '0;
          p12_q <= '0;
        end
        3'd5: begin
          p21_q <= '0;
          p22_q <= '0;
        end
        3'd6: begin
          q11_q <= '0;
          q12_q <= '0;
        end
        default: begin
          q21_q <= '0;
          q22_q <= '0;
        end
      endcase
    end
    if (cmd_i.cap_r) begin
      r_q <= sval;
    end
    if (cmd_i.swap) begin
      ca_q  <= cb_q;
      cb_q  <= ca_q;
      a_q   <= b_q;
      b_q   <= a_q;
      a1_q  <= b1_q;
      b1_q  <= a1_q;
      a2_q  <= b2_q;
      b2_q  <= a2_q;
      p11_q <= q11_q;
      q11_q <= p11_q;
      p12_q <= q12_q;
      q12_q <= p12_q;
      p21_q <= q21_q;
      q21_q <= p21_q;
      p22_q <= q22_q;
      q22_q <= p22_q;
    end
    if (cmd_i.res_take) begin
      res_q <= xv;
    end else if (cmd_i.res_scan) begin
      res_q <= sval;
    end
  end

  assign result_char_o = res_q;
  assign status_o      = stat_q;

endmodule

// ===== sv/rcl_ctrl.sv =====
// Sequencer that steps through item decode, decomposition scans and the rule program.
module rcl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          cmd_i,
  input  rcl_pkg::dp_stat_t   stat_i,
  output rcl_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy,
  output logic                done_o
);

  rcl_pkg::state_e              state_q, state_d;
  logic [rcl_pkg::RuleIdxW-1:0] idx_q, idx_d;
  logic                         pass_q, pass_d;
  logic                         advance, adv_prep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcl_pkg::ST_IDLE;
      idx_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pass_d   = pass_q;
    cmd_o    = '0;
    cmd_o.idx = idx_q;
    advance  = 1'b0;
    adv_prep = 1'b0;
    busy     = state_q != rcl_pkg::ST_IDLE;
    done_o   = 1'b0;
    unique case (state_q)
      rcl_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.ld_in = 1'b1;
          state_d = rcl_pkg::ST_DONE;
          case (cmd_i)
            rcl_pkg::CMD_LOAD:  cmd_o.do_load = 1'b1;
            rcl_pkg::CMD_CLEAR: cmd_o.do_clear = 1'b1;
            rcl_pkg::CMD_QUERY: begin
              state_d = rcl_pkg::ST_PREP;
              idx_d   = '0;
              pass_d  = 1'b0;
            end
            default: state_d = rcl_pkg::ST_DONE;
          endcase
        end
      end
      rcl_pkg::ST_PREP: begin
        if (stat_i.prep_skip) begin
          cmd_o.prep_zero = 1'b1;
          adv_prep = 1'b1;
        end else begin
          cmd_o.prep_start = 1'b1;
          state_d = rcl_pkg::ST_PREP_WAIT;
        end
      end
      rcl_pkg::ST_PREP_WAIT: begin
        if (stat_i.scan_done) begin
          cmd_o.prep_cap = 1'b1;
          adv_prep = 1'b1;
        end
      end
      rcl_pkg::ST_RULE: begin
        if (stat_i.rule_skip) begin
          advance = 1'b1;
        end else if (stat_i.kind == rcl_pkg::RK_TAKE) begin
          if (stat_i.take_ok) begin
            cmd_o.res_take = 1'b1;
            state_d = rcl_pkg::ST_DONE;
          end else begin
            advance = 1'b1;
          end
        end else begin
          cmd_o.rule_start1 = 1'b1;
          state_d = rcl_pkg::ST_SCAN1;
        end
      end
      rcl_pkg::ST_SCAN1: begin
        if (stat_i.scan_done) begin
          if (stat_i.kind == rcl_pkg::RK_CHAIN) begin
            if (stat_i.scan_nz) begin
              cmd_o.cap_r = 1'b1;
              state_d = rcl_pkg::ST_CHAIN;
            end else begin
              advance = 1'b1;
            end
          end else if (stat_i.scan_ok) begin
            cmd_o.res_scan = 1'b1;
            state_d = rcl_pkg::ST_DONE;
          end else begin
            advance = 1'b1;
          end
        end
      end
      rcl_pkg::ST_CHAIN: begin
        cmd_o.rule_start2 = 1'b1;
        state_d = rcl_pkg::ST_SCAN2;
      end
      rcl_pkg::ST_SCAN2: begin
        if (stat_i.scan_done) begin
          if (stat_i.scan_ok) begin
            cmd_o.res_scan = 1'b1;
            state_d = rcl_pkg::ST_DONE;
          end else begin
            advance = 1'b1;
          end
        end
      end
      rcl_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = rcl_pkg::ST_IDLE;
      end
      default: state_d = rcl_pkg::ST_IDLE;
    endcase

    if (adv_prep) begin
      if (idx_q == rcl_pkg::RuleIdxW'(rcl_pkg::NumPrep - 1)) begin
        idx_d   = '0;
        state_d = rcl_pkg::ST_RULE;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = rcl_pkg::ST_PREP;
      end
    end

    if (advance) begin
      if (idx_q == rcl_pkg::RuleIdxW'(rcl_pkg::NumRules - 1)) begin
        if (!pass_q) begin
          cmd_o.swap = 1'b1;
          pass_d  = 1'b1;
          idx_d   = '0;
          state_d = rcl_pkg::ST_RULE;
        end else begin
          state_d = rcl_pkg::ST_DONE;
        end
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = rcl_pkg::ST_RULE;
      end
    end
  end

endmodule
